// ===== src/pnoise_pkg.sv =====
package pnoise_pkg;

	// Fixed formats
	localparam int FRAC_BITS  = 16;
	localparam int TBL_W      = 8;
	localparam int TABLE_SIZE = 256;
	localparam int COORD_W    = 32;
	localparam int XS_W       = FRAC_BITS + TBL_W;
	localparam int NOISE_W    = 21;
	localparam int OUT_LIMIT  = 524288;
	localparam int OCT_CNT_W  = 4;
	localparam int PERS_W     = 17;
	localparam int WQ_BITS    = 16;
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 1'd1;

	// Command codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef struct packed {
		logic [OCT_CNT_W-1:0] octave_count;
		logic [PERS_W-1:0]    persistence;
	} cfg_t;

	typedef struct packed {
		logic             op;
		logic [TBL_W-1:0] index;
		logic [TBL_W-1:0] value;
		logic [XS_W-1:0]  x;
		logic [XS_W-1:0]  y;
	} cmd_t;

endpackage

// ===== src/pnoise_if.sv =====
interface pnoise_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  table_index;
	logic [7:0]  table_value;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;

	modport source(output valid, req_type, table_index, table_value, x_coord, y_coord,
		input ready);
	modport sink(input valid, req_type, table_index, table_value, x_coord, y_coord,
		output ready);
endinterface

interface pnoise_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [20:0] noise_value;

	modport source(output valid, noise_value, input ready);
	modport sink(input valid, noise_value, output ready);
endinterface

// ===== src/pnoise_ram.sv =====
module pnoise_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read on one port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== src/pnoise_front.sv =====
module pnoise_front (
	input  logic                 clk,
	input  logic                 arst_n,
	pnoise_req_if.sink           req,
	output pnoise_pkg::cmd_t     cmd,
	output logic                 cmd_valid,
	input  logic                 cmd_pop
);

	localparam int DEPTH = pnoise_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pnoise_pkg::cmd_t fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	pnoise_pkg::cmd_t cmd_in;

	assign req.ready = (count_q != CNT_W'(DEPTH));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	// Classify the incoming word and keep only the coordinate bits that matter
	always_comb begin
		cmd_in.op    = req.req_type ? pnoise_pkg::OP_EVAL : pnoise_pkg::OP_WRITE;
		cmd_in.index = req.table_index;
		cmd_in.value = req.table_value;
		cmd_in.x     = req.x_coord[pnoise_pkg::XS_W-1:0];
		cmd_in.y     = req.y_coord[pnoise_pkg::XS_W-1:0];
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(cmd_pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue overfilled");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> count_q != '0) else $error("pop from empty queue");
`endif

endmodule

// ===== src/pnoise_div.sv =====
module pnoise_div #(
	parameter int DVD_W = 53,
	parameter int DVS_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVS_W:0]   trial, diff;
	logic             fits;

	// One quotient bit per cycle, restoring
	assign trial    = {rem_q, quo_q[DVD_W-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign diff     = trial - {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			// Pulse done after the last quotient bit
			done <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== src/pnoise_back.sv =====
module pnoise_back #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pnoise_pkg::cmd_t cmd,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  pnoise_pkg::cfg_t cfg,
	pnoise_rsp_if.source     rsp
);

	localparam int F     = pnoise_pkg::FRAC_BITS;
	localparam int XS_W  = pnoise_pkg::XS_W;
	localparam int TW    = pnoise_pkg::TBL_W;
	localparam int P_W   = F + 5;
	localparam int FD_W  = F + 5;
	localparam int D_W   = F + 2;
	localparam int G_W   = F + 5;
	localparam int L_W   = F + 7;
	localparam int N_W   = F + 7;
	localparam int W_W   = 17 + MAX_OCTAVES;
	localparam int PW_W  = N_W + W_W + 1;
	localparam int TOT_W = PW_W + $clog2(MAX_OCTAVES + 1);
	localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
	localparam int Q_W   = TOT_W + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_A    = 4'd1;
	localparam logic [3:0] S_B    = 4'd2;
	localparam logic [3:0] S_C    = 4'd3;
	localparam logic [3:0] S_D    = 4'd4;
	localparam logic [3:0] S_E    = 4'd5;
	localparam logic [3:0] S_F    = 4'd6;
	localparam logic [3:0] S_G    = 4'd7;
	localparam logic [3:0] S_H    = 4'd8;
	localparam logic [3:0] S_I    = 4'd9;
	localparam logic [3:0] S_J    = 4'd10;
	localparam logic [3:0] S_K    = 4'd11;
	localparam logic [3:0] S_L    = 4'd12;
	localparam logic [3:0] S_DIV  = 4'd13;
	localparam logic [3:0] S_WAIT = 4'd14;
	localparam logic [3:0] S_OUT  = 4'd15;

	localparam logic signed [Q_W-1:0] LIM_HI = Q_W'(pnoise_pkg::OUT_LIMIT);
	localparam logic signed [Q_W-1:0] LIM_LO = -Q_W'(pnoise_pkg::OUT_LIMIT);
	localparam logic signed [D_W-1:0] D_ONE  = D_W'(1 << F);

	logic [3:0]       state_q;
	logic [XS_W-1:0]  x_q, y_q;
	logic [OCT_W-1:0] oct_q, n_oct_q;
	logic [W_W-1:0]   w_q, wsum_q;
	logic [W_W+pnoise_pkg::PERS_W-1:0] wp_q;
	logic signed [TOT_W-1:0] total_q;
	logic signed [PW_W-1:0]  prodw_q;
	logic [TW-1:0]    pa_q, pb_q, h00_q, h10_q, h01_q, h11_q;
	logic [F-1:0]     t2x_q, t2y_q, t3x_q, t3y_q;
	logic [P_W-1:0]   px_q, py_q;
	logic [FD_W-1:0]  u_q, v_q;
	logic signed [G_W-1:0] g00_q, g10_q, g01_q, g11_q;
	logic signed [L_W-1:0] l0_q, l1_q;
	logic signed [N_W-1:0] n_q;
	logic             rsp_valid_q;
	logic signed [pnoise_pkg::NOISE_W-1:0] noise_q;

	logic [TW-1:0]    cx, cy, ram_addr, ram_rdata;
	logic [F-1:0]     fx, fy;
	logic             ram_we;
	logic [OCT_W-1:0] n_start;
	logic             div_start, div_done;
	logic [TOT_W-1:0] div_quo, total_mag;
	logic signed [Q_W-1:0] q_signed;
	logic signed [pnoise_pkg::NOISE_W-1:0] noise_d;
	logic             sign_q;
	logic signed [D_W-1:0] dx0, dy0, dx1, dy1;
	logic signed [G_W:0]   dg0, dg1;
	logic signed [2*G_W+2:0] pl0, pl1;
	logic signed [L_W:0]   dl;
	logic signed [L_W+FD_W+1:0] pn;

	function automatic logic signed [G_W-1:0] corner(input logic [TW-1:0] h,
		input logic signed [D_W-1:0] dx, input logic signed [D_W-1:0] dy);
		logic signed [D_W-1:0] d;
		logic signed [G_W-1:0] g;
		logic [3:0]            mag;
		mag = {1'b0, h[2:0]} + 4'd1;
		d   = h[0] ? dx : dy;
		g   = G_W'(d) * $signed({1'b0, mag});
		return h[3] ? -g : g;
	endfunction

	assign cx = x_q[XS_W-1:F];
	assign cy = y_q[XS_W-1:F];
	assign fx = x_q[F-1:0];
	assign fy = y_q[F-1:0];
	assign cmd_pop = cmd_valid && (state_q == S_IDLE);
	assign ram_we  = cmd_pop && (cmd.op == pnoise_pkg::OP_WRITE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.noise_value = noise_q;

	// Table address by step
	always_comb begin
		case (state_q)
			S_IDLE:  ram_addr = cmd.index;
			S_A:     ram_addr = cx;
			S_B:     ram_addr = cx + 1'b1;
			S_C:     ram_addr = pa_q + cy;
			S_D:     ram_addr = pb_q + cy;
			S_E:     ram_addr = pa_q + cy + 1'b1;
			S_F:     ram_addr = pb_q + cy + 1'b1;
			default: ram_addr = cx;
		endcase
	end

	pnoise_ram #(.WIDTH(TW), .DEPTH(pnoise_pkg::TABLE_SIZE)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (cmd.value),
		.rdata (ram_rdata)
	);

	// Clamp octave count into 1..MAX_OCTAVES
	always_comb begin
		if (cfg.octave_count == '0) begin
			n_start = OCT_W'(1);
		end else if (int'(cfg.octave_count) > MAX_OCTAVES) begin
			n_start = OCT_W'(MAX_OCTAVES);
		end else begin
			n_start = OCT_W'(cfg.octave_count);
		end
	end

	// Corner offsets and lerp products
	always_comb begin
		dx0 = $signed({2'b0, fx});
		dy0 = $signed({2'b0, fy});
		dx1 = dx0 - D_ONE;
		dy1 = dy0 - D_ONE;
		dg0 = (G_W+1)'(g10_q) - (G_W+1)'(g00_q);
		dg1 = (G_W+1)'(g11_q) - (G_W+1)'(g01_q);
		pl0 = (2*G_W+3)'(dg0) * (2*G_W+3)'($signed({1'b0, u_q}));
		pl1 = (2*G_W+3)'(dg1) * (2*G_W+3)'($signed({1'b0, u_q}));
		dl  = (L_W+1)'(l1_q) - (L_W+1)'(l0_q);
		pn  = (L_W+FD_W+2)'(dl) * (L_W+FD_W+2)'($signed({1'b0, v_q}));
	end

	// Divider on the magnitude of the weighted sum
	assign total_mag = total_q[TOT_W-1] ? TOT_W'(-total_q) : TOT_W'(total_q);
	assign div_start = (state_q == S_DIV);

	pnoise_div #(.DVD_W(TOT_W), .DVS_W(W_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_mag),
		.divisor  (wsum_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Restore sign and saturate
	always_comb begin
		q_signed = sign_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		if (q_signed > LIM_HI) begin
			noise_d = pnoise_pkg::NOISE_W'(LIM_HI);
		end else if (q_signed < LIM_LO) begin
			noise_d = pnoise_pkg::NOISE_W'(LIM_LO);
		end else begin
			noise_d = pnoise_pkg::NOISE_W'(q_signed);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q     <= cmd.x;
				y_q     <= cmd.y;
				n_oct_q <= n_start;
				w_q     <= W_W'(1 << pnoise_pkg::WQ_BITS);
				wsum_q  <= '0;
				total_q <= '0;
			end
			S_A: begin
				t2x_q <= F'((2*F)'(fx) * (2*F)'(fx) >> F);
				t2y_q <= F'((2*F)'(fy) * (2*F)'(fy) >> F);
			end
			S_B: begin
				pa_q  <= ram_rdata;
				t3x_q <= F'((2*F)'(t2x_q) * (2*F)'(fx) >> F);
				t3y_q <= F'((2*F)'(t2y_q) * (2*F)'(fy) >> F);
				px_q  <= P_W'(6 * (P_W+1)'(t2x_q) + (P_W+1)'(10 << F) - 15 * (P_W+1)'(fx));
				py_q  <= P_W'(6 * (P_W+1)'(t2y_q) + (P_W+1)'(10 << F) - 15 * (P_W+1)'(fy));
			end
			S_C: begin
				pb_q <= ram_rdata;
				u_q  <= FD_W'((F+P_W)'(t3x_q) * (F+P_W)'(px_q) >> F);
				v_q  <= FD_W'((F+P_W)'(t3y_q) * (F+P_W)'(py_q) >> F);
			end
			S_D: h00_q <= ram_rdata;
			S_E: h10_q <= ram_rdata;
			S_F: h01_q <= ram_rdata;
			S_G: h11_q <= ram_rdata;
			S_H: begin
				g00_q <= corner(h00_q, dx0, dy0);
				g10_q <= corner(h10_q, dx1, dy0);
				g01_q <= corner(h01_q, dx0, dy1);
				g11_q <= corner(h11_q, dx1, dy1);
			end
			S_I: begin
				l0_q <= L_W'(g00_q) + L_W'(pl0 >>> F);
				l1_q <= L_W'(g01_q) + L_W'(pl1 >>> F);
			end
			S_J: n_q <= N_W'(l0_q) + N_W'(pn >>> F);
			S_K: begin
				prodw_q <= PW_W'(n_q) * $signed({1'b0, w_q});
				wp_q    <= w_q * cfg.persistence;
			end
			S_L: begin
				total_q <= total_q + TOT_W'(prodw_q);
				wsum_q  <= wsum_q + w_q;
				w_q     <= W_W'(wp_q >> pnoise_pkg::WQ_BITS);
				x_q     <= {x_q[XS_W-2:0], 1'b0};
				y_q     <= {y_q[XS_W-2:0], 1'b0};
			end
			S_DIV: sign_q <= total_q[TOT_W-1];
			default: begin
			end
		endcase
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			oct_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Load a result word from S_OUT, drop it once taken
			if (state_q == S_OUT && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					oct_q <= '0;
					if (cmd_valid && cmd.op == pnoise_pkg::OP_EVAL) begin
						state_q <= S_A;
					end
				end
				S_L: begin
					oct_q <= oct_q + 1'b1;
					state_q <= (oct_q == n_oct_q - 1'b1) ? S_DIV : S_A;
				end
				S_WAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= state_q + 1'b1;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!rsp_valid_q || rsp.ready)) begin
			noise_q <= noise_d;
		end
	end

`ifndef ASSERT_OFF
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_IDLE) else $error("table write outside idle");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_WAIT) else $error("divider result unexpected");
`endif

endmodule

// ===== src/perlin_noise_2d_octaves_unit.sv =====
// Channel  Dir  Payload
// req      in   req_type, table_index, table_value, x_coord, y_coord
// rsp      out  noise_value (one word per evaluation, none per table write)
// cfg      in   cfg_we, cfg_index, cfg_wdata (octave_count, persistence)
//
// A table write is done by the back end while it is idle. An evaluation runs
// twelve sequencer steps per octave, six of which read the single-port table,
// then the serial divider, which yields one quotient bit per cycle (TOT_W is
// 53 at eight octaves).
// A two-word queue lets requests land while the back end works or rsp stalls.
// Reset clears control state; table contents are undefined until written.
module perlin_noise_2d_octaves_unit #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	pnoise_req_if.sink                          req,
	pnoise_rsp_if.source                        rsp,
	input  logic                                cfg_we,
	input  logic [pnoise_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pnoise_pkg::PERS_W-1:0]       cfg_wdata
);

	pnoise_pkg::cfg_t cfg_q;
	pnoise_pkg::cmd_t cmd;
	logic             cmd_valid, cmd_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.octave_count <= pnoise_pkg::OCT_CNT_W'(4);
			cfg_q.persistence  <= pnoise_pkg::PERS_W'(32768);
		end else if (cfg_we) begin
			case (cfg_index)
				pnoise_pkg::REG_OCTAVE_COUNT:
					cfg_q.octave_count <= cfg_wdata[pnoise_pkg::OCT_CNT_W-1:0];
				pnoise_pkg::REG_PERSISTENCE:
					cfg_q.persistence <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	pnoise_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	pnoise_back #(.MAX_OCTAVES(MAX_OCTAVES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg_q),
		.rsp       (rsp)
	);

endmodule
